FILE: rtl/acpu_pkg.sv
`timescale 1ns / 1ps

package acpu_pkg;

	localparam int WORD_W = 16;
	localparam int ADDR_W = 12;

	localparam logic [WORD_W-1:0] ADDR_MASK = 16'h0FFF;

	typedef enum logic [1:0] {
		FN_RUN   = 2'd0,
		FN_WRITE = 2'd1,
		FN_READ  = 2'd2,
		FN_POWER = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		OP_HLT = 4'd0,
		OP_ADD = 4'd1,
		OP_XOR = 4'd2,
		OP_AND = 4'd3,
		OP_IOR = 4'd4,
		OP_NOT = 4'd5,
		OP_LDA = 4'd6,
		OP_STA = 4'd7,
		OP_SRJ = 4'd8,
		OP_JMA = 4'd9,
		OP_JMP = 4'd10,
		OP_INP = 4'd11,
		OP_OUT = 4'd12,
		OP_RAL = 4'd13,
		OP_CSA = 4'd14,
		OP_NOP = 4'd15
	} op_t;

	// architectural machine state
	typedef struct packed {
		logic              running;
		logic              phase;
		logic [WORD_W-1:0] pc;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] ir;
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] mar;
		logic [WORD_W-1:0] mbr;
	} mach_t;

	// store request from the execute cycle of STA (address is MAR)
	typedef struct packed {
		logic              we;
		logic [WORD_W-1:0] data;
	} wr_req_t;

endpackage

FILE: rtl/acpu_ram.sv
`timescale 1ns / 1ps

module acpu_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [acpu_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [acpu_pkg::WORD_W-1:0] rdata
);
	import acpu_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/acpu_core.sv
`timescale 1ns / 1ps

module acpu_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  acpu_pkg::func_t             func,
	input  logic [acpu_pkg::WORD_W-1:0] rdata,
	input  logic [acpu_pkg::WORD_W-1:0] switch_word,
	output acpu_pkg::mach_t             state,
	output acpu_pkg::wr_req_t           sta_req
);
	import acpu_pkg::*;

	mach_t             st_q;
	mach_t             st_d;
	op_t               op_f;
	op_t               op_x;
	logic [WORD_W-1:0] pc_inc;
	logic [WORD_W-1:0] f_addr;
	logic [WORD_W-1:0] sum;
	logic              ovf;

	assign op_f   = op_t'(rdata[15:12]);
	assign op_x   = op_t'(st_q.ir[15:12]);
	assign pc_inc = st_q.pc + 16'd1;
	assign f_addr = rdata & ADDR_MASK;
	assign sum    = st_q.z + rdata;
	assign ovf    = (st_q.z[15] == rdata[15]) && (sum[15] != st_q.z[15]);

	always_comb begin
		st_d         = st_q;
		sta_req.we   = 1'b0;
		sta_req.data = st_q.acc;
		if (func == FN_POWER) begin
			st_d.running = 1'b1;
		end else if (func == FN_RUN && st_q.running) begin
			if (st_q.phase) begin
				// execute cycle: rdata is the word at MAR
				case (op_x)
					OP_ADD: begin
						st_d.mbr = rdata;
						st_d.acc = sum;
						if (ovf) begin
							st_d.running = 1'b0;
						end
					end
					OP_XOR: begin
						st_d.mbr = rdata;
						st_d.acc = st_q.z ^ rdata;
					end
					OP_AND: begin
						st_d.mbr = rdata;
						st_d.acc = st_q.z & rdata;
					end
					OP_IOR: begin
						st_d.mbr = rdata;
						st_d.acc = st_q.z | rdata;
					end
					OP_NOT: st_d.acc = ~st_q.z;
					OP_LDA: begin
						st_d.mbr = rdata;
						st_d.acc = rdata;
					end
					OP_STA: begin
						st_d.mbr   = st_q.acc;
						sta_req.we = fire;
					end
					OP_RAL: st_d.acc = {st_q.z[14:0], st_q.z[15]};
					default: ;
				endcase
				st_d.mar   = st_q.pc;
				st_d.phase = 1'b0;
			end else begin
				// fetch cycle: rdata is the word at PC
				st_d.pc  = pc_inc;
				st_d.mbr = rdata;
				st_d.ir  = rdata;
				case (op_f)
					OP_HLT: begin
						st_d.running = 1'b0;
						st_d.mar     = pc_inc;
					end
					OP_ADD, OP_XOR, OP_AND, OP_IOR: begin
						st_d.z     = st_q.acc;
						st_d.mar   = f_addr;
						st_d.phase = 1'b1;
					end
					OP_NOT, OP_RAL: begin
						st_d.z     = st_q.acc;
						st_d.phase = 1'b1;
					end
					OP_LDA, OP_STA: begin
						st_d.mar   = f_addr;
						st_d.phase = 1'b1;
					end
					OP_SRJ: begin
						st_d.acc = pc_inc & ADDR_MASK;
						st_d.pc  = f_addr;
						st_d.mar = f_addr;
					end
					OP_JMA: begin
						if (st_q.acc[15]) begin
							st_d.pc  = f_addr;
							st_d.mar = f_addr;
						end else begin
							st_d.mar = pc_inc;
						end
					end
					OP_JMP: begin
						st_d.pc  = f_addr;
						st_d.mar = f_addr;
					end
					OP_CSA: begin
						st_d.acc = switch_word;
						st_d.mar = pc_inc;
					end
					default: st_d.mar = pc_inc;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign state = st_q;

`ifndef SYNTHESIS
	// execute phase only follows a fetch of an opcode that has an execute cycle
	a_exec_op: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase |-> (op_x == OP_ADD || op_x == OP_XOR || op_x == OP_AND ||
			op_x == OP_IOR || op_x == OP_NOT || op_x == OP_LDA ||
			op_x == OP_STA || op_x == OP_RAL))
		else $error("execute phase with single-cycle opcode");

	// a halted machine ignores machine cycles
	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && func == FN_RUN && !st_q.running) |=> $stable(st_q))
		else $error("state changed while halted");

	// memory store only from the execute cycle of STA
	a_sta_write: assert property (@(posedge clk) disable iff (!arst_n)
		sta_req.we |-> (fire && st_q.running && st_q.phase && op_x == OP_STA))
		else $error("store outside STA execute");
`endif

endmodule

FILE: rtl/accumulator_cpu_instruction_cycle_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------------
// in        in_valid / in_stall       func, mem_addr, mem_data
// out       out_valid / out_stall     running, phase, prog_counter, accumulator,
//                                     instr_word, operand_latch, mem_addr_reg,
//                                     mem_buffer_reg, read_data
// cfg       cfg_valid / cfg_ready     cfg_data (switch register)
//
// The transfer cycle of an item issues the memory read (at MAR for a machine
// cycle, at mem_addr otherwise); the update stage then uses the read word to
// update registers and write memory. The next read depends on the MAR that this
// update leaves, so in_stall is high while an item sits in the update stage.
// The update stage waits while a result is held under out_stall; the register
// outputs stay stable meanwhile, as the machine state only moves
// when a new result is loaded. Reset clears the machine registers, both valid
// flags and the switch register; memory contents are left as they are and need
// no sweep.

module accumulator_cpu_instruction_cycle_top #(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [11:0] mem_addr,
	input  logic [15:0] mem_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        running,
	output logic        phase,
	output logic [15:0] prog_counter,
	output logic [15:0] accumulator,
	output logic [15:0] instr_word,
	output logic [15:0] operand_latch,
	output logic [15:0] mem_addr_reg,
	output logic [15:0] mem_buffer_reg,
	output logic [15:0] read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import acpu_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [16:0] MW = 17'(MEM_WORDS);

	// 12-bit address reduced modulo the memory depth: for a depth of at least 256
	// words the quotient is below 16, so four conditional subtracts do it
	function automatic logic [AW-1:0] word_index(input logic [ADDR_W-1:0] a);
		logic [16:0] r;
		r = {5'd0, a};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (MW << k)) begin
				r = r - (MW << k);
			end
		end
		return r[AW-1:0];
	endfunction

	logic              in_xfer;
	logic              fire;
	logic              valid_s1;
	func_t             func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_W-1:0] data_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] sw_q;
	mach_t             st;
	wr_req_t           sta_req;
	logic [WORD_W-1:0] mem_rdata;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic              we;

	assign in_stall = valid_s1;
	assign in_xfer  = in_valid && !in_stall;
	// update stage completes when the result register is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);

	// read at MAR for machine cycles, at mem_addr for everything else
	assign raddr = (func_t'(func) == FN_RUN) ? word_index(st.mar[ADDR_W-1:0])
		: word_index(mem_addr);

	assign we    = fire && ((func_s1 == FN_WRITE) || sta_req.we);
	assign waddr = (func_s1 == FN_WRITE) ? word_index(addr_s1)
		: word_index(st.mar[ADDR_W-1:0]);
	assign wdata = (func_s1 == FN_WRITE) ? data_s1 : sta_req.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= func_t'(func);
			addr_s1 <= mem_addr;
			data_s1 <= mem_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q <= (func_s1 == FN_READ) ? mem_rdata : '0;
		end
	end

	// switch register: always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			sw_q <= cfg_data;
		end
	end

	acpu_ram #(
		.DEPTH(MEM_WORDS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (in_xfer),
		.raddr(raddr),
		.rdata(mem_rdata)
	);

	acpu_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (func_s1),
		.rdata      (mem_rdata),
		.switch_word(sw_q),
		.state      (st),
		.sta_req    (sta_req)
	);

	assign out_valid      = out_valid_q;
	assign running        = st.running;
	assign phase          = st.phase;
	assign prog_counter   = st.pc;
	assign accumulator    = st.acc;
	assign instr_word     = st.ir;
	assign operand_latch  = st.z;
	assign mem_addr_reg   = st.mar;
	assign mem_buffer_reg = st.mbr;
	assign read_data      = rd_q;

`ifndef SYNTHESIS
	// read issue and register update never share a cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_xfer && fire))
		else $error("transfer accepted during update");

	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted item lost before update");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("update without result");
`endif

endmodule

FILE: tb/tb_accumulator_cpu_instruction_cycle_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the accumulator CPU. Commands are planned ahead
// against a shadow machine so that no step ever reads a memory word that was
// never written. Every input transfer is re-predicted on a live machine copy,
// and every output transfer is compared field by field with the oldest
// prediction.

module tb_accumulator_cpu_instruction_cycle_top;

	import acpu_pkg::*;

	localparam int MEM_WORDS    = 4096;
	localparam int DRAIN_CYCLES = 8;     // extra cycles waited after both queues are empty
	localparam int STALL_LIMIT  = 1000;  // cycles without any transfer

	typedef struct packed {
		func_t       fn;
		logic [11:0] addr;
		logic [15:0] data;
	} cmd_t;

	typedef struct packed {
		mach_t       regs;
		logic [15:0] rd;
	} cpu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [11:0] mem_addr = '0;
	logic [15:0] mem_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        running;
	logic        phase;
	logic [15:0] prog_counter;
	logic [15:0] accumulator;
	logic [15:0] instr_word;
	logic [15:0] operand_latch;
	logic [15:0] mem_addr_reg;
	logic [15:0] mem_buffer_reg;
	logic [15:0] read_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// commands waiting for an input transfer, predicted states waiting for output
	cmd_t        cmd_q[$];
	cpu_result_t cpu_state_q[$];

	// planning copy: advanced when a command is queued
	mach_t       plan = '0;
	logic [15:0] plan_switch = '0;
	logic [15:0] plan_mem [MEM_WORDS];
	bit          plan_written [MEM_WORDS];
	logic [11:0] written_list[$];

	// live copy: advanced on each input transfer
	mach_t       live_state = '0;
	logic [15:0] live_switch = '0;
	logic [15:0] live_mem [MEM_WORDS];

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int cmds_planned = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int machine_cycles = 0;
	int halt_count = 0;
	int switch_writes = 0;
	int quiet_cycles = 0;

	accumulator_cpu_instruction_cycle_top #(
		.MEM_WORDS(MEM_WORDS)
	) uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// One command on one machine. 'word' is the memory word at the index the
	// command reads: mem_addr for a read, MAR for anything else.
	function automatic void cpu_cycle(
		input  mach_t       cur,
		input  logic [15:0] sw,
		input  func_t       fn,
		input  logic [11:0] addr,
		input  logic [15:0] data,
		input  logic [15:0] word,
		output mach_t       nxt,
		output logic [15:0] rd,
		output logic        we,
		output logic [11:0] widx,
		output logic [15:0] wdata
	);
		logic [15:0] field;
		logic [15:0] sum;
		op_t         op;
		nxt = cur;
		rd = '0;
		we = 1'b0;
		widx = addr;
		wdata = data;
		case (fn)
			FN_WRITE: we = 1'b1;
			FN_READ:  rd = word;
			FN_POWER: nxt.running = 1'b1;
			FN_RUN: begin
				if (cur.running && !cur.phase) begin
					// fetch: IR from the word at MAR, PC already bumped
					nxt.pc = cur.pc + 16'd1;
					nxt.mbr = word;
					nxt.ir = word;
					field = word & ADDR_MASK;
					op = op_t'(word[15:12]);
					nxt.mar = nxt.pc;
					case (op)
						OP_HLT: nxt.running = 1'b0;
						OP_ADD, OP_XOR, OP_AND, OP_IOR: begin
							nxt.z = cur.acc;
							nxt.mar = field;
							nxt.phase = 1'b1;
						end
						OP_NOT, OP_RAL: begin
							nxt.z = cur.acc;
							nxt.mar = cur.mar;
							nxt.phase = 1'b1;
						end
						OP_LDA, OP_STA: begin
							nxt.mar = field;
							nxt.phase = 1'b1;
						end
						OP_SRJ: begin
							nxt.acc = nxt.pc & ADDR_MASK;
							nxt.pc = field;
							nxt.mar = field;
						end
						OP_JMA: begin
							if (cur.acc[15])
								nxt.pc = field;
							nxt.mar = nxt.pc;
						end
						OP_JMP: begin
							nxt.pc = field;
							nxt.mar = field;
						end
						OP_CSA: nxt.acc = sw;
						default: ;
					endcase
				end else if (cur.running) begin
					op = op_t'(cur.ir[15:12]);
					case (op)
						OP_ADD: begin
							sum = cur.z + word;
							nxt.mbr = word;
							nxt.acc = sum;
							// same-sign operands, result sign flipped: power off
							if (cur.z[15] == word[15] && sum[15] != cur.z[15])
								nxt.running = 1'b0;
						end
						OP_XOR: begin
							nxt.mbr = word;
							nxt.acc = cur.z ^ word;
						end
						OP_AND: begin
							nxt.mbr = word;
							nxt.acc = cur.z & word;
						end
						OP_IOR: begin
							nxt.mbr = word;
							nxt.acc = cur.z | word;
						end
						OP_NOT: nxt.acc = ~cur.z;
						OP_RAL: nxt.acc = {cur.z[14:0], cur.z[15]};
						OP_LDA: begin
							nxt.mbr = word;
							nxt.acc = word;
						end
						OP_STA: begin
							nxt.mbr = cur.acc;
							we = 1'b1;
							widx = cur.mar[11:0];
							wdata = cur.acc;
						end
						default: ;
					endcase
					nxt.mar = cur.pc;
					nxt.phase = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// queue a command and advance the planning copy
	task automatic plan_push(input func_t fn, input logic [11:0] addr,
			input logic [15:0] data);
		mach_t       nxt;
		logic [15:0] rd;
		logic        we;
		logic [11:0] widx;
		logic [15:0] wdata;
		cpu_cycle(plan, plan_switch, fn, addr, data,
			plan_mem[fn == FN_READ ? addr : plan.mar[11:0]],
			nxt, rd, we, widx, wdata);
		if (we) begin
			plan_mem[widx] = wdata;
			if (!plan_written[widx]) begin
				plan_written[widx] = 1'b1;
				written_list.insert(written_list.size(), widx);
			end
		end
		plan = nxt;
		cmd_q.insert(cmd_q.size(), cmd_t'{fn, addr, data});
		cmds_planned++;
	endtask

	// queue one machine cycle; the word it will read is written first if it
	// is still blank. With 'refresh' the next instruction is sometimes replaced
	// so that tight loops get broken up.
	task automatic plan_run(input bit refresh);
		logic [11:0] idx;
		logic        reads;
		op_t         new_op;
		idx = plan.mar[11:0];
		reads = plan.running && (!plan.phase ||
			op_t'(plan.ir[15:12]) inside {OP_ADD, OP_XOR, OP_AND, OP_IOR, OP_LDA});
		new_op = ($urandom_range(99) < 3) ? OP_HLT : op_t'(4'($urandom_range(15, 1)));
		if (reads && (!plan_written[idx] ||
				(refresh && !plan.phase && $urandom_range(15) == 0)))
			plan_push(FN_WRITE, idx, plan.phase ? 16'($urandom) :
				{new_op, 12'($urandom_range(4095))});
		plan_push(FN_RUN, 12'($urandom_range(4095)), 16'($urandom));
	endtask

	task automatic set_switch(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		plan_switch = value;
		switch_writes++;
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || cpu_state_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// queues about 'count' commands, memory fills included
	task automatic random_phase(input int count);
		int start;
		int pick;
		start = cmds_planned;
		while (cmds_planned - start < count) begin
			pick = $urandom_range(99);
			if (!plan.running && pick < 70) begin
				plan_push(FN_POWER, 12'($urandom_range(4095)), 16'($urandom));
			end else if (pick < 6) begin
				plan_push(FN_WRITE, 12'($urandom_range(4095)), 16'($urandom));
			end else if (pick < 12) begin
				plan_push(FN_READ, written_list[$urandom_range(written_list.size() - 1)],
					16'($urandom));
			end else if (pick < 15) begin
				plan_push(FN_POWER, 12'($urandom_range(4095)), 16'($urandom));
			end else begin
				plan_run(1'b1);
			end
		end
	endtask

	// Driver: presents the head of cmd_q; on each input transfer the live copy
	// is stepped and the resulting state queued for the output side.
	always @(posedge clk) begin : drive_proc
		cmd_t        cmd;
		mach_t       nxt;
		logic [15:0] rd;
		logic        we;
		logic [11:0] widx;
		logic [15:0] wdata;
		if (cfg_valid && cfg_ready)
			live_switch = cfg_data;
		if (in_valid && !in_stall) begin
			cmd = cmd_q.pop_front();
			cpu_cycle(live_state, live_switch, cmd.fn, cmd.addr, cmd.data,
				live_mem[cmd.fn == FN_READ ? cmd.addr : live_state.mar[11:0]],
				nxt, rd, we, widx, wdata);
			if (we)
				live_mem[widx] = wdata;
			cmds_accepted++;
			if (cmd.fn == FN_RUN && live_state.running)
				machine_cycles++;
			if (live_state.running && !nxt.running)
				halt_count++;
			live_state = nxt;
			cpu_state_q.insert(cpu_state_q.size(), cpu_result_t'{nxt, rd});
		end
		// a stalled transfer holds its payload
		if (!(in_valid && in_stall)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				in_valid <= 1'b1;
				func <= cmd_q[0].fn;
				mem_addr <= cmd_q[0].addr;
				mem_data <= cmd_q[0].data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, compare each output transfer
	always @(posedge clk) begin : check_proc
		cpu_result_t want;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (out_valid && !out_stall) begin
			if (cpu_state_q.size() == 0) begin
				$error("result transfer with no prediction pending");
				mismatch_count++;
			end else begin
				want = cpu_state_q.pop_front();
				results_checked++;
				if (running !== want.regs.running) begin
					$error("running: expected %h, got %h", want.regs.running, running);
					mismatch_count++;
				end
				if (phase !== want.regs.phase) begin
					$error("phase: expected %h, got %h", want.regs.phase, phase);
					mismatch_count++;
				end
				if (prog_counter !== want.regs.pc) begin
					$error("prog_counter: expected %h, got %h", want.regs.pc, prog_counter);
					mismatch_count++;
				end
				if (accumulator !== want.regs.acc) begin
					$error("accumulator: expected %h, got %h", want.regs.acc, accumulator);
					mismatch_count++;
				end
				if (instr_word !== want.regs.ir) begin
					$error("instr_word: expected %h, got %h", want.regs.ir, instr_word);
					mismatch_count++;
				end
				if (operand_latch !== want.regs.z) begin
					$error("operand_latch: expected %h, got %h", want.regs.z, operand_latch);
					mismatch_count++;
				end
				if (mem_addr_reg !== want.regs.mar) begin
					$error("mem_addr_reg: expected %h, got %h", want.regs.mar, mem_addr_reg);
					mismatch_count++;
				end
				if (mem_buffer_reg !== want.regs.mbr) begin
					$error("mem_buffer_reg: expected %h, got %h", want.regs.mbr,
						mem_buffer_reg);
					mismatch_count++;
				end
				if (read_data !== want.rd) begin
					$error("read_data: expected %h, got %h", want.rd, read_data);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on any channel
	always @(posedge clk) begin : watchdog_proc
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d cycles without a transfer", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stim_proc
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed program, switches all ones.
		//   0: CSA          A = FFFF
		//   1: JMA 003      sign set, taken
		//   3: ADD FFF      FFFF + 8000 overflows, machine halts
		//   4: RAL          7FFF rotates to FFFE
		//   5: HLT
		// Also: both address extremes, data 0000 and FFFF, a cycle while halted,
		// and power-on keeping all registers.
		set_switch(16'hFFFF);
		plan_push(FN_WRITE, 12'hFFF, 16'h8000);
		plan_push(FN_WRITE, 12'h000, {OP_CSA, 12'h000});
		plan_push(FN_WRITE, 12'h001, {OP_JMA, 12'h003});
		plan_push(FN_WRITE, 12'h002, 16'hFFFF);
		plan_push(FN_WRITE, 12'h003, {OP_ADD, 12'hFFF});
		plan_push(FN_WRITE, 12'h004, {OP_RAL, 12'h000});
		plan_push(FN_WRITE, 12'h005, 16'h0000);
		plan_push(FN_READ, 12'hFFF, 16'h0000);
		plan_push(FN_READ, 12'h002, 16'hFFFF);
		plan_run(1'b0);                            // halted: no effect
		plan_push(FN_POWER, 12'h000, 16'h0000);
		repeat (4) plan_run(1'b0);                 // CSA, JMA, ADD fetch, ADD execute
		plan_run(1'b0);                            // halted after overflow
		plan_push(FN_POWER, 12'hFFF, 16'hFFFF);
		repeat (3) plan_run(1'b0);                 // RAL fetch, RAL execute, HLT
		plan_push(FN_POWER, 12'h000, 16'h0000);
		drain();

		// random programs under three handshake mixes
		gap_pct = 10;
		stall_pct = 56;
		set_switch(16'h0000);
		random_phase(300);
		drain();

		gap_pct = 56;
		stall_pct = 10;
		set_switch(16'($urandom));
		random_phase(300);
		drain();

		gap_pct = 0;
		stall_pct = 0;
		set_switch(16'h8000);
		random_phase(300);
		drain();

		$display("covered %0d commands: %0d machine cycles, %0d halts, %0d switch settings",
			cmds_accepted, machine_cycles, halt_count, switch_writes);
		$display("compared %0d results, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
